FILE: design/lzsd_pkg.sv
package lzsd_pkg;

  localparam int RING_SIZE_DEF = 4096;
  // Write position starts this far below the top of the ring (0xFEE for 4 KiB).
  localparam int START_GAP     = 18;
  localparam int LEN_BIAS      = 3;

  typedef struct packed {
    logic clearing;
    logic in_fire;
    logic copy_adv;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ref_start;
    logic copy_last;
    logic out_free;
  } sts_t;

endpackage

FILE: design/lzss_ring_decompressor_core.sv
// LZSS decoder with a 4 KiB history ring. Feed the compressed stream after its
// header one byte per item on in_*, and write the decompressed length to
// cfg_wr_data with cfg_wr_en before each stream (this also restarts the flag
// parser and sets the write position to 0xFEE; the ring contents are kept).
// After reset the ring is cleared to zero, during which in_stall stays high.
// A flag byte, the first byte of a reference and a literal are each taken
// in ST_IDLE. The single read port of the ring has registered read data, so
// after the second byte of a reference ST_PRIME starts the ring read and
// ST_COPY then copies the bytes out, holding while the output is stalled.
// Up to 18 bytes per reference, out_run_last on the last one and on every
// literal, out_stream_done on the byte that brings the count to zero; once
// the count is zero further input items are taken and dropped.
module lzss_ring_decompressor_core
  import lzsd_pkg::*;
#(
  parameter int RING_SIZE = RING_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_stream_done,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzsd_dp #(
    .RING_SIZE (RING_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_byte         (in_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

endmodule

FILE: design/lzsd_ram.sv
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read of the address written in the same cycle returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lzsd_ctrl.sv
module lzsd_ctrl
  import lzsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PRIME = 4'b0100,
    ST_COPY  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;
  logic   copy_adv;

  assign in_stall = !((state_r == ST_IDLE) && sts.out_free);
  assign in_fire  = in_valid && !in_stall;
  assign copy_adv = (state_r == ST_COPY) && sts.out_free;

  assign cmd.clearing = (state_r == ST_CLEAR);
  assign cmd.in_fire  = in_fire;
  assign cmd.copy_adv = copy_adv;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && sts.ref_start) state_nxt = ST_PRIME;
      end
      ST_PRIME: begin
        state_nxt = ST_COPY;
      end
      ST_COPY: begin
        if (copy_adv && sts.copy_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/lzsd_dp.sv
module lzsd_dp
  import lzsd_pkg::*;
#(
  parameter int RING_SIZE = RING_SIZE_DEF,
  localparam int AW       = $clog2(RING_SIZE)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_byte,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_stream_done
);

  localparam logic [AW-1:0] START_POS = AW'(RING_SIZE - START_GAP);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_SIZE - 1);

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [4:0]    len_r, len_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [8:0]    flag_r, flag_nxt;
  logic          phase_r, phase_nxt;
  logic [7:0]    held_r, held_nxt;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          run_last_r, run_last_nxt;
  logic          done_r, done_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          live;
  logic          need_flag;
  logic          lit_fire;
  logic [7:0]    copy_byte;
  logic          out_free;

  assign live      = (rem_r != 32'd0);
  assign need_flag = (flag_r[8:1] == 8'd0);
  assign lit_fire  = cmd.in_fire && live && !phase_r && !need_flag && flag_r[0];
  // The byte just written may be the one read next: take it from the bypass.
  assign copy_byte = fwd_r ? fwd_data_r : ram_rdata;
  assign out_free  = !out_valid_r || !out_stall;

  assign sts.clr_done  = (clr_cnt_r == LAST_ADDR);
  assign sts.ref_start = live && phase_r;
  assign sts.copy_last = (len_r == 5'd1) || (rem_r == 32'd1);
  assign sts.out_free  = out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = in_byte;
    if (cmd.clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 8'd0;
    end else if (cmd.copy_adv) begin
      ram_we    = 1'b1;
      ram_wdata = copy_byte;
    end else if (lit_fire) begin
      ram_we    = 1'b1;
    end
  end

  // Hold the read address while the output is stalled so the data stays put.
  assign ram_raddr = cmd.copy_adv ? src_r + AW'(1) : src_r;

  always_comb begin
    clr_cnt_nxt   = cmd.clearing ? clr_cnt_r + AW'(1) : clr_cnt_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    flag_nxt      = flag_r;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    run_last_nxt  = run_last_r;
    done_nxt      = done_r;

    if (cfg_wr_en) begin
      rem_nxt   = cfg_wr_data;
      wp_nxt    = START_POS;
      flag_nxt  = 9'd1;
      phase_nxt = 1'b0;
      held_nxt  = 8'd0;
    end else if (cmd.copy_adv) begin
      wp_nxt        = wp_r + AW'(1);
      src_nxt       = src_r + AW'(1);
      len_nxt       = len_r - 5'd1;
      rem_nxt       = rem_r - 32'd1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = copy_byte;
      run_last_nxt  = sts.copy_last;
      done_nxt      = (rem_r == 32'd1);
    end else if (cmd.in_fire && live) begin
      if (phase_r) begin
        src_nxt   = AW'({in_byte[7:4], held_r});
        len_nxt   = {1'b0, in_byte[3:0]} + 5'(LEN_BIAS);
        phase_nxt = 1'b0;
        flag_nxt  = {1'b0, flag_r[8:1]};
      end else if (need_flag) begin
        flag_nxt = {1'b1, in_byte};
      end else if (flag_r[0]) begin
        wp_nxt        = wp_r + AW'(1);
        rem_nxt       = rem_r - 32'd1;
        flag_nxt      = {1'b0, flag_r[8:1]};
        out_valid_nxt = 1'b1;
        out_byte_nxt  = in_byte;
        run_last_nxt  = 1'b1;
        done_nxt      = (rem_r == 32'd1);
      end else begin
        held_nxt  = in_byte;
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      wp_r        <= START_POS;
      rem_r       <= 32'd0;
      flag_r      <= 9'd1;
      phase_r     <= 1'b0;
      held_r      <= 8'd0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      rem_r       <= rem_nxt;
      flag_r      <= flag_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      fwd_r       <= ram_we && (ram_waddr == ram_raddr);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    len_r      <= len_nxt;
    fwd_data_r <= ram_wdata;
    out_byte_r <= out_byte_nxt;
    run_last_r <= run_last_nxt;
    done_r     <= done_nxt;
  end

  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = run_last_r;
  assign out_stream_done = done_r;

endmodule

FILE: design/lzsd_chk.sv
module lzsd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_stream_done
);

  // The ring clear follows every reset: no item may enter right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during ring clear");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // The byte that ends the stream always ends its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("stream end without run end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_run_last) && $stable(out_stream_done))
    else $error("stalled output item changed");

endmodule

bind lzss_ring_decompressor_core lzsd_chk u_lzsd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_run_last    (out_run_last),
  .out_stream_done (out_stream_done)
);
